@@ rtl/core/q4dec_pkg.sv @@
// shared types and constants for the q4.28 decimal text converter
`default_nettype none

package q4dec_pkg;

  localparam int unsigned FRACTION_DIGITS_DEF = 8;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned INT_W    = 4;
  localparam int unsigned FRAC_W   = 27;
  // fraction times ten: 27 bits plus four carry bits
  localparam int unsigned PROD_W   = FRAC_W + 4;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_DOT   = 7'h2E;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;

  // one classified word, as queued between front and back
  typedef struct packed {
    logic              neg;
    logic [INT_W-1:0]  int_digit;
    logic [FRAC_W-1:0] frac;
  } q4dec_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q4dec_fifo_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_INT  = 4'b0010,
    ST_DOT  = 4'b0100,
    ST_FRAC = 4'b1000
  } q4dec_state_e;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [INT_W-1:0] d);
    digit_char = CHAR_ZERO + {{(CHAR_W-INT_W){1'b0}}, d};
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/q4_28_to_decimal_ascii.sv @@
// top level of the q4.28 to decimal ascii converter
`default_nettype none

// Converts each signed Q4.28 word into its decimal text, one ASCII character
// per output transaction: an optional '-', one integer digit, '.', then
// FRACTION_DIGITS truncated fraction digits, the last flagged by last_char_o.
// A word yields 2 + FRACTION_DIGITS characters, one more when negative (10 or
// 11 with the default), one per cycle from the back end's output register
// while out_stall_i is low; consecutive words follow with no gap. The front end
// classifies a word in the cycle it arrives and parks it in a two-entry queue,
// so input keeps flowing while the back end is busy or stalled, until it fills.
module q4_28_to_decimal_ascii #(
  parameter int unsigned FRACTION_DIGITS = q4dec_pkg::FRACTION_DIGITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] fixed_word_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic [6:0]  char_code_o,
  output logic        last_char_o,
  output logic        out_valid_o,
  input  logic        out_stall_i
);
  import q4dec_pkg::*;

  q4dec_fifo_stat_t fifo_stat;
  q4dec_entry_t     push_entry;
  q4dec_entry_t     pop_entry;
  logic             push;
  logic             pop;

  q4dec_front u_front (
    .fixed_word_i (fixed_word_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .fifo_stat_i  (fifo_stat),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  q4dec_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry),
    .stat_o       (fifo_stat)
  );

  q4dec_back #(
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_stat_i (fifo_stat),
    .pop_entry_i (pop_entry),
    .pop_o       (pop),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

endmodule

`default_nettype wire

@@ rtl/core/q4dec_front.sv @@
// front end: takes in words, splits sign, integer digit and fraction
`default_nettype none

module q4dec_front (
  input  logic [31:0]             fixed_word_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  q4dec_pkg::q4dec_fifo_stat_t fifo_stat_i,
  output logic                    push_o,
  output q4dec_pkg::q4dec_entry_t push_entry_o
);
  import q4dec_pkg::*;

  logic [WORD_W-1:0] mag;

  // most negative word negates to itself and reads as eight
  assign mag = fixed_word_i[WORD_W-1] ? (~fixed_word_i + 32'd1) : fixed_word_i;

  assign push_entry_o.neg       = fixed_word_i[WORD_W-1];
  assign push_entry_o.int_digit = mag[WORD_W-1 -: INT_W];
  assign push_entry_o.frac      = mag[FRAC_W:1];

  assign in_stall_o = fifo_stat_i.full;
  assign push_o     = in_valid_i && !fifo_stat_i.full;

endmodule

`default_nettype wire

@@ rtl/core/q4dec_fifo.sv @@
// two-entry queue between front and back
`default_nettype none

module q4dec_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  q4dec_pkg::q4dec_entry_t push_entry_i,
  input  logic                    pop_i,
  output q4dec_pkg::q4dec_entry_t pop_entry_o,
  output q4dec_pkg::q4dec_fifo_stat_t stat_o
);
  import q4dec_pkg::*;

  q4dec_entry_t mem_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign stat_o.full  = count_q[1];
  assign stat_o.empty = (count_q == 2'd0);

endmodule

`default_nettype wire

@@ rtl/core/q4dec_back.sv @@
// back end: serialises one queued word into characters
`default_nettype none

module q4dec_back #(
  parameter int unsigned FRACTION_DIGITS = q4dec_pkg::FRACTION_DIGITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  q4dec_pkg::q4dec_fifo_stat_t fifo_stat_i,
  input  q4dec_pkg::q4dec_entry_t pop_entry_i,
  output logic                    pop_o,
  output logic [6:0]              char_code_o,
  output logic                    last_char_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i
);
  import q4dec_pkg::*;

  localparam int unsigned CntW = $clog2(FRACTION_DIGITS + 1);
  localparam logic [CntW-1:0] CntLast = CntW'(FRACTION_DIGITS - 1);

  q4dec_state_e      state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [INT_W-1:0]  int_q, int_d;
  logic [FRAC_W-1:0] frac_q, frac_d;
  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic              last_q, last_d;
  logic              adv;
  logic [PROD_W-1:0] prod;

  // output slot is free or being taken this cycle
  assign adv  = !out_valid_q || !out_stall_i;
  // times ten as shift and add
  assign prod = {1'b0, frac_q, 3'b000} + {3'b000, frac_q, 1'b0};

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    int_d       = int_q;
    frac_d      = frac_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    pop_o       = 1'b0;
    if (adv) begin
      out_valid_d = 1'b0;
      last_d      = 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (!fifo_stat_i.empty) begin
            pop_o       = 1'b1;
            out_valid_d = 1'b1;
            int_d       = pop_entry_i.int_digit;
            frac_d      = pop_entry_i.frac;
            if (pop_entry_i.neg) begin
              char_d  = CHAR_MINUS;
              state_d = ST_INT;
            end else begin
              char_d  = digit_char(pop_entry_i.int_digit);
              state_d = ST_DOT;
            end
          end
        end
        ST_INT: begin
          out_valid_d = 1'b1;
          char_d      = digit_char(int_q);
          state_d     = ST_DOT;
        end
        ST_DOT: begin
          out_valid_d = 1'b1;
          char_d      = CHAR_DOT;
          cnt_d       = '0;
          state_d     = ST_FRAC;
        end
        ST_FRAC: begin
          out_valid_d = 1'b1;
          char_d      = digit_char(prod[PROD_W-1 -: INT_W]);
          frac_d      = prod[FRAC_W-1:0];
          if (cnt_q == CntLast) begin
            last_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    int_q  <= int_d;
    frac_q <= frac_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

endmodule

`default_nettype wire

@@ rtl/core/q4dec_checker.sv @@
// port-level checks for the converter, bound to the top level
`default_nettype none

module q4dec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic [6:0]  char_code_o,
  input logic        last_char_o,
  input logic        out_valid_o,
  input logic        out_stall_i
);
  import q4dec_pkg::*;

  // a stalled transaction keeps its valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped under stall");

  // closing character is always a digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_char_o |-> char_code_o >= CHAR_ZERO && char_code_o <= CHAR_NINE)
    else $error("last character is not a digit");

  // only sign, point or digits appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> char_code_o == CHAR_MINUS || char_code_o == CHAR_DOT
      || (char_code_o >= CHAR_ZERO && char_code_o <= CHAR_NINE))
    else $error("illegal character code");

  // a sign is always followed by an integer digit, never a point or another sign
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && char_code_o == CHAR_MINUS ##1 out_valid_o
      |-> char_code_o >= CHAR_ZERO && char_code_o <= CHAR_NINE && !last_char_o)
    else $error("sign not followed by integer digit");

endmodule

bind q4_28_to_decimal_ascii q4dec_checker u_q4dec_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .char_code_o (char_code_o),
  .last_char_o (last_char_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);

`default_nettype wire
